// ===== rtl/core/bsf_pkg.sv =====
package bsf_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int CfgWidth   = 32;
  localparam int AddrWidth  = 3;

  localparam int LenWidth = CoordWidth + 1;
  localparam int SqWidth  = 2 * LenWidth;
  localparam int MagWidth = LenWidth + CfgWidth - FracBits;
  localparam int MagLo    = MagWidth / 2;
  localparam int MagHi    = MagWidth - MagLo;
  localparam int NumWidth = MagWidth + LenWidth;
  localparam int CmpWidth = (LenWidth > CfgWidth) ? LenWidth : CfgWidth;

  localparam logic [CfgWidth-1:0] SpringConstantReset = CfgWidth'(1) << FracBits;
  localparam logic [CfgWidth-1:0] RestLengthReset     = CfgWidth'(1) << FracBits;

  typedef enum logic {
    RegSpringConstant = 1'b0,
    RegRestLength     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] particle_x;
    logic signed [CoordWidth-1:0] particle_y;
    logic signed [CoordWidth-1:0] other_x;
    logic signed [CoordWidth-1:0] other_y;
  } in_req_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] force_x;
    logic signed [CoordWidth-1:0] force_y;
    logic                         applied;
    logic                         saturated;
  } out_res_t;

  typedef struct packed {
    logic                neg_x;
    logic                neg_y;
    logic [LenWidth-1:0] ax;
    logic [LenWidth-1:0] ay;
  } side_t;

  typedef struct packed {
    logic slack;
    logic neg_x;
    logic neg_y;
  } ctl_t;

endpackage

// ===== rtl/core/bungee_spring_force_2d.sv =====
// Channel  | Ports                                   | Handshake
// request  | start, busy, in_req                     | taken when start && !busy
// result   | out_valid, out_res                      | one-cycle strobe, no backpressure
// config   | psel, penable, pwrite, paddr, pwdata,   | APB, pready tied high
//          | prdata, pready                          |
//
// The pipeline computes difference and square, one square-root stage per length
// bit, scaling and partial products, one divider stage per magnitude bit, then
// saturation.
// One request enters per cycle; busy stays low.
// Synchronous active-low reset clears the valid bits and loads k = L = 1.0.
// Results cannot be stalled; each is shown for exactly one cycle.
module bungee_spring_force_2d (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  bsf_pkg::in_req_t                in_req,
  output logic                            out_valid,
  output bsf_pkg::out_res_t               out_res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bsf_pkg::AddrWidth-1:0]   paddr,
  input  logic [bsf_pkg::CfgWidth-1:0]    pwdata,
  output logic [bsf_pkg::CfgWidth-1:0]    prdata,
  output logic                            pready
);
  import bsf_pkg::*;

  localparam logic [MagWidth-1:0] MinMag = MagWidth'(1) << (CoordWidth-1);
  localparam logic [CoordWidth-1:0] ForceMin = {1'b1, {(CoordWidth-1){1'b0}}};
  localparam logic [CoordWidth-1:0] ForceMax = {1'b0, {(CoordWidth-1){1'b1}}};

  logic [CfgWidth-1:0] spring_constant_r, rest_length_r;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  logic                sum_valid;
  logic [SqWidth-1:0]  sum;
  side_t               sum_side;
  logic                len_valid;
  logic [LenWidth-1:0] len;
  side_t               len_side;
  logic                num_valid;
  logic [NumWidth-1:0] num_x, num_y;
  logic [LenWidth-1:0] num_len;
  ctl_t                num_ctl;
  logic                q_valid;
  logic [MagWidth-1:0] q_x, q_y;
  ctl_t                q_ctl;

  logic                out_valid_r;
  out_res_t            out_res_r, res_nxt;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spring_constant_r <= SpringConstantReset;
      rest_length_r     <= RestLengthReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegSpringConstant: spring_constant_r <= pwdata;
        RegRestLength:     rest_length_r     <= pwdata;
        default:           spring_constant_r <= spring_constant_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegSpringConstant: prdata = spring_constant_r;
      RegRestLength:     prdata = rest_length_r;
      default:           prdata = '0;
    endcase
  end

  bsf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (start & ~busy),
    .req       (in_req),
    .sum_valid (sum_valid),
    .sum       (sum),
    .side      (sum_side)
  );

  bsf_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .rad_valid (sum_valid),
    .rad       (sum),
    .side      (sum_side),
    .len_valid (len_valid),
    .len       (len),
    .len_side  (len_side)
  );

  bsf_scale u_scale (
    .clk             (clk),
    .rst_n           (rst_n),
    .len_valid       (len_valid),
    .len             (len),
    .side            (len_side),
    .spring_constant (spring_constant_r),
    .rest_length     (rest_length_r),
    .num_valid       (num_valid),
    .num_x           (num_x),
    .num_y           (num_y),
    .num_len         (num_len),
    .num_ctl         (num_ctl)
  );

  bsf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .num_valid (num_valid),
    .num_x     (num_x),
    .num_y     (num_y),
    .num_len   (num_len),
    .num_ctl   (num_ctl),
    .q_valid   (q_valid),
    .q_x       (q_x),
    .q_y       (q_y),
    .q_ctl     (q_ctl)
  );

  // clip each component; force points against d; zero when slack
  always_comb begin
    logic sat_x, sat_y;
    logic [CoordWidth-1:0] fx, fy;
    if (!q_ctl.neg_x) begin
      sat_x = q_x > MinMag;
      fx    = sat_x ? ForceMin : CoordWidth'(MagWidth'(0) - q_x);
    end else begin
      sat_x = q_x >= MinMag;
      fx    = sat_x ? ForceMax : q_x[CoordWidth-1:0];
    end
    if (!q_ctl.neg_y) begin
      sat_y = q_y > MinMag;
      fy    = sat_y ? ForceMin : CoordWidth'(MagWidth'(0) - q_y);
    end else begin
      sat_y = q_y >= MinMag;
      fy    = sat_y ? ForceMax : q_y[CoordWidth-1:0];
    end
    if (q_ctl.slack) begin
      res_nxt = '0;
    end else begin
      res_nxt.force_x   = fx;
      res_nxt.force_y   = fy;
      res_nxt.applied   = 1'b1;
      res_nxt.saturated = sat_x | sat_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_slack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.applied |->
      out_res.force_x == '0 && out_res.force_y == '0 && !out_res.saturated)
    else $error("slack result carries force");

  a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.saturated |->
      out_res.force_x == ForceMin || out_res.force_x == ForceMax ||
      out_res.force_y == ForceMin || out_res.force_y == ForceMax)
    else $error("saturation flagged without a clipped component");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && cfg_idx == RegRestLength |=> rest_length_r == $past(pwdata))
    else $error("rest length write lost");

endmodule

// ===== rtl/core/bsf_front.sv =====
module bsf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         req_valid,
  input  bsf_pkg::in_req_t             req,
  output logic                         sum_valid,
  output logic [bsf_pkg::SqWidth-1:0]  sum,
  output bsf_pkg::side_t               side
);
  import bsf_pkg::*;

  logic [3:0]          v_r;
  logic [LenWidth-1:0] dx_r, dy_r;
  side_t               side2_r, side3_r, side4_r;
  logic [SqWidth-1:0]  sx_r, sy_r, sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], req_valid};
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= {req.particle_x[CoordWidth-1], req.particle_x}
          - {req.other_x[CoordWidth-1], req.other_x};
    dy_r <= {req.particle_y[CoordWidth-1], req.particle_y}
          - {req.other_y[CoordWidth-1], req.other_y};

    side2_r.neg_x <= dx_r[LenWidth-1];
    side2_r.neg_y <= dy_r[LenWidth-1];
    side2_r.ax    <= dx_r[LenWidth-1] ? (~dx_r + 1'b1) : dx_r;
    side2_r.ay    <= dy_r[LenWidth-1] ? (~dy_r + 1'b1) : dy_r;

    sx_r    <= SqWidth'(side2_r.ax) * SqWidth'(side2_r.ax);
    sy_r    <= SqWidth'(side2_r.ay) * SqWidth'(side2_r.ay);
    side3_r <= side2_r;

    sum_r   <= sx_r + sy_r;
    side4_r <= side3_r;
  end

  assign sum_valid = v_r[3];
  assign sum       = sum_r;
  assign side      = side4_r;

endmodule

// ===== rtl/core/bsf_isqrt.sv =====
module bsf_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rad_valid,
  input  logic [bsf_pkg::SqWidth-1:0]   rad,
  input  bsf_pkg::side_t                side,
  output logic                          len_valid,
  output logic [bsf_pkg::LenWidth-1:0]  len,
  output bsf_pkg::side_t                len_side
);
  import bsf_pkg::*;

  logic [LenWidth-1:0] v_r, v_nxt;
  logic [LenWidth:0]   rem_r  [LenWidth];
  logic [LenWidth:0]   rem_nxt[LenWidth];
  logic [LenWidth-1:0] root_r  [LenWidth];
  logic [LenWidth-1:0] root_nxt[LenWidth];
  logic [SqWidth-1:0]  rad_r  [LenWidth];
  logic [SqWidth-1:0]  rad_nxt[LenWidth];
  side_t               side_r  [LenWidth];
  side_t               side_nxt[LenWidth];

  always_comb begin
    logic [LenWidth:0]   rem_in;
    logic [LenWidth-1:0] root_in;
    logic [SqWidth-1:0]  rad_in;
    logic [LenWidth+2:0] cat, trial;
    logic                fit;
    for (int i = 0; i < LenWidth; i++) begin
      if (i == 0) begin
        rem_in      = '0;
        root_in     = '0;
        rad_in      = rad;
        side_nxt[i] = side;
        v_nxt[i]    = rad_valid;
      end else begin
        rem_in      = rem_r[i-1];
        root_in     = root_r[i-1];
        rad_in      = rad_r[i-1];
        side_nxt[i] = side_r[i-1];
        v_nxt[i]    = v_r[i-1];
      end
      cat         = {rem_in, rad_in[SqWidth-1 -: 2]};
      trial       = {1'b0, root_in, 2'b01};
      fit         = cat >= trial;
      rem_nxt[i]  = fit ? (LenWidth+1)'(cat - trial) : cat[LenWidth:0];
      root_nxt[i] = {root_in[LenWidth-2:0], fit};
      rad_nxt[i]  = rad_in << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LenWidth; i++) begin
      rem_r[i]  <= rem_nxt[i];
      root_r[i] <= root_nxt[i];
      rad_r[i]  <= rad_nxt[i];
      side_r[i] <= side_nxt[i];
    end
  end

  assign len_valid = v_r[LenWidth-1];
  assign len       = root_r[LenWidth-1];
  assign len_side  = side_r[LenWidth-1];

endmodule

// ===== rtl/core/bsf_scale.sv =====
module bsf_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          len_valid,
  input  logic [bsf_pkg::LenWidth-1:0]  len,
  input  bsf_pkg::side_t                side,
  input  logic [bsf_pkg::CfgWidth-1:0]  spring_constant,
  input  logic [bsf_pkg::CfgWidth-1:0]  rest_length,
  output logic                          num_valid,
  output logic [bsf_pkg::NumWidth-1:0]  num_x,
  output logic [bsf_pkg::NumWidth-1:0]  num_y,
  output logic [bsf_pkg::LenWidth-1:0]  num_len,
  output bsf_pkg::ctl_t                 num_ctl
);
  import bsf_pkg::*;

  localparam int ProdWidth = LenWidth + CfgWidth;

  logic [3:0]                v_r;
  logic [LenWidth-1:0]       s_a_r;
  logic [LenWidth-1:0]       len_a_r, len_b_r, len_c_r, len_d_r;
  side_t                     side_a_r, side_b_r;
  ctl_t                      ctl_a_r, ctl_b_r, ctl_c_r, ctl_d_r;
  logic [MagWidth-1:0]       m_b_r;
  logic [ProdWidth-1:0]      prod;
  logic [MagLo+LenWidth-1:0] pxl_r, pyl_r;
  logic [MagHi+LenWidth-1:0] pxh_r, pyh_r;
  logic [NumWidth-1:0]       num_x_r, num_y_r;

  assign prod = ProdWidth'(s_a_r) * ProdWidth'(spring_constant);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], len_valid};
    end
  end

  always_ff @(posedge clk) begin
    s_a_r         <= LenWidth'(CmpWidth'(len) - CmpWidth'(rest_length));
    ctl_a_r.slack <= CmpWidth'(len) <= CmpWidth'(rest_length);
    ctl_a_r.neg_x <= side.neg_x;
    ctl_a_r.neg_y <= side.neg_y;
    len_a_r       <= len;
    side_a_r      <= side;

    m_b_r    <= prod[ProdWidth-1:FracBits];
    len_b_r  <= len_a_r;
    side_b_r <= side_a_r;
    ctl_b_r  <= ctl_a_r;

    pxl_r   <= (MagLo+LenWidth)'(m_b_r[MagLo-1:0]) * (MagLo+LenWidth)'(side_b_r.ax);
    pxh_r   <= (MagHi+LenWidth)'(m_b_r[MagWidth-1:MagLo]) * (MagHi+LenWidth)'(side_b_r.ax);
    pyl_r   <= (MagLo+LenWidth)'(m_b_r[MagLo-1:0]) * (MagLo+LenWidth)'(side_b_r.ay);
    pyh_r   <= (MagHi+LenWidth)'(m_b_r[MagWidth-1:MagLo]) * (MagHi+LenWidth)'(side_b_r.ay);
    len_c_r <= len_b_r;
    ctl_c_r <= ctl_b_r;

    num_x_r <= NumWidth'(pxl_r) + (NumWidth'(pxh_r) << MagLo);
    num_y_r <= NumWidth'(pyl_r) + (NumWidth'(pyh_r) << MagLo);
    len_d_r <= len_c_r;
    ctl_d_r <= ctl_c_r;
  end

  assign num_valid = v_r[3];
  assign num_x     = num_x_r;
  assign num_y     = num_y_r;
  assign num_len   = len_d_r;
  assign num_ctl   = ctl_d_r;

endmodule

// ===== rtl/core/bsf_div.sv =====
module bsf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          num_valid,
  input  logic [bsf_pkg::NumWidth-1:0]  num_x,
  input  logic [bsf_pkg::NumWidth-1:0]  num_y,
  input  logic [bsf_pkg::LenWidth-1:0]  num_len,
  input  bsf_pkg::ctl_t                 num_ctl,
  output logic                          q_valid,
  output logic [bsf_pkg::MagWidth-1:0]  q_x,
  output logic [bsf_pkg::MagWidth-1:0]  q_y,
  output bsf_pkg::ctl_t                 q_ctl
);
  import bsf_pkg::*;

  logic [MagWidth-1:0] v_r, v_nxt;
  logic [LenWidth-1:0] rx_r[MagWidth], rx_nxt[MagWidth];
  logic [LenWidth-1:0] ry_r[MagWidth], ry_nxt[MagWidth];
  logic [MagWidth-1:0] lx_r[MagWidth], lx_nxt[MagWidth];
  logic [MagWidth-1:0] ly_r[MagWidth], ly_nxt[MagWidth];
  logic [LenWidth-1:0] d_r [MagWidth], d_nxt [MagWidth];
  ctl_t                c_r [MagWidth], c_nxt [MagWidth];

  always_comb begin
    logic [LenWidth-1:0] rx, ry, d;
    logic [MagWidth-1:0] lx, ly;
    logic [LenWidth:0]   cx, cy;
    logic                fx, fy;
    for (int i = 0; i < MagWidth; i++) begin
      if (i == 0) begin
        rx       = num_x[NumWidth-1 -: LenWidth];
        ry       = num_y[NumWidth-1 -: LenWidth];
        lx       = num_x[MagWidth-1:0];
        ly       = num_y[MagWidth-1:0];
        d        = num_len;
        c_nxt[i] = num_ctl;
        v_nxt[i] = num_valid;
      end else begin
        rx       = rx_r[i-1];
        ry       = ry_r[i-1];
        lx       = lx_r[i-1];
        ly       = ly_r[i-1];
        d        = d_r[i-1];
        c_nxt[i] = c_r[i-1];
        v_nxt[i] = v_r[i-1];
      end
      cx        = {rx, lx[MagWidth-1]};
      cy        = {ry, ly[MagWidth-1]};
      fx        = cx >= {1'b0, d};
      fy        = cy >= {1'b0, d};
      rx_nxt[i] = fx ? LenWidth'(cx - {1'b0, d}) : cx[LenWidth-1:0];
      ry_nxt[i] = fy ? LenWidth'(cy - {1'b0, d}) : cy[LenWidth-1:0];
      lx_nxt[i] = {lx[MagWidth-2:0], fx};
      ly_nxt[i] = {ly[MagWidth-2:0], fy};
      d_nxt[i]  = d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MagWidth; i++) begin
      rx_r[i] <= rx_nxt[i];
      ry_r[i] <= ry_nxt[i];
      lx_r[i] <= lx_nxt[i];
      ly_r[i] <= ly_nxt[i];
      d_r[i]  <= d_nxt[i];
      c_r[i]  <= c_nxt[i];
    end
  end

  assign q_valid = v_r[MagWidth-1];
  assign q_x     = lx_r[MagWidth-1];
  assign q_y     = ly_r[MagWidth-1];
  assign q_ctl   = c_r[MagWidth-1];

endmodule
